>>> rtl/mm_pkg.sv
`default_nettype none

package mm_pkg;

    // request kinds carried in tuser of the input stream
    localparam logic [1:0] REQ_LOAD_A = 2'd0;
    localparam logic [1:0] REQ_LOAD_B = 2'd1;
    localparam logic [1:0] REQ_QUERY  = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_ROWS_A    = 2'd0;
    localparam logic [1:0] CFG_INNER_LEN = 2'd1;
    localparam logic [1:0] CFG_COLS_B    = 2'd2;

    localparam int IDX_W   = 4;   // row / column field width
    localparam int ELEM_W  = 16;  // Q8.8 element
    localparam int SIZE_W  = 5;   // size register width
    localparam int PROD_W  = 32;  // Q16.16 product of two elements
    localparam int ACC_W   = 37;  // Q21.16 sum

    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 40;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 5'd16;

    // controls from the sequencer into the multiply-accumulate unit
    typedef struct packed {
        logic clear;     // start a new sum
        logic in_valid;  // operand pair present this cycle
    } t_mac_ctl;

endpackage

`default_nettype wire

>>> rtl/mm_mac.sv
`default_nettype none

module mm_mac (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire mm_pkg::t_mac_ctl                  i_ctl,
    input  wire logic signed [mm_pkg::ELEM_W-1:0]  i_a,
    input  wire logic signed [mm_pkg::ELEM_W-1:0]  i_b,
    output logic                                   o_busy,
    output logic signed [mm_pkg::ACC_W-1:0]        o_acc
);
    import mm_pkg::*;

    logic signed [PROD_W-1:0] r_prod;
    logic                     r_prod_v;
    logic signed [ACC_W-1:0]  r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_v <= 1'b0;
        end else begin
            r_prod_v <= i_ctl.in_valid;
        end
    end

    // register the product before it reaches the adder
    always_ff @(posedge i_clk) begin
        if (i_ctl.in_valid) begin
            r_prod <= i_a * i_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.clear) begin
            r_acc <= '0;
        end else if (r_prod_v) begin
            r_acc <= r_acc + ACC_W'(r_prod);
        end
    end

    assign o_busy = r_prod_v;
    assign o_acc  = r_acc;

endmodule

`default_nettype wire

>>> rtl/matrix_multiply_top.sv
`default_nettype none
// Load words (A or B element) are taken whenever the sequencer idles.
// A query word in range sums n products in the run state, n = min(inner_len, MAX_DIM);
// one read of each store per cycle feeds a single multiply-accumulate, and no new word is
// taken until the done state has loaded the sum into the output register and the sequencer idles.
// An out-of-range query goes from idle straight to the done state and then to the output register;
// a result word held by the sink stalls a following query. Synchronous active-low reset.
module matrix_multiply_top #(
    parameter int MAX_DIM = 16
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // configuration write channel
    input  wire logic                             i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire logic [1:0]                       i_cfg_index,
    input  wire logic [mm_pkg::SIZE_W-1:0]        i_cfg_data,
    // input stream
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    // tdata: row_index[3:0], col_index[7:4], elem_value[23:8]
    input  wire logic [mm_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // tuser: req_type[1:0]
    input  wire logic [1:0]                       s_axis_tuser,
    // result stream
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    // tdata: product_value[36:0], zero fill [39:37]
    output logic [mm_pkg::OUT_DATA_W-1:0]         m_axis_tdata,
    // tuser: out_of_range[0]
    output logic                                  m_axis_tuser
);
    import mm_pkg::*;

    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = $clog2(DEPTH);
    localparam int KW    = $clog2(MAX_DIM + 1);
    localparam int SZW   = (KW > SIZE_W) ? KW : SIZE_W;
    localparam logic [AW-1:0]  DIM_A = AW'(MAX_DIM);
    localparam logic [SZW-1:0] DIM_S = SZW'(MAX_DIM);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DONE
    } t_state;

    // size registers
    logic [SIZE_W-1:0] r_rows_a;
    logic [SIZE_W-1:0] r_inner_len;
    logic [SIZE_W-1:0] r_cols_b;

    // sequencer
    t_state            r_state;
    logic [IDX_W-1:0]  r_row;
    logic [IDX_W-1:0]  r_col;
    logic [KW-1:0]     r_n;
    logic [KW-1:0]     r_kcnt;
    logic              r_rd_v;
    logic              r_oor;

    // output register
    logic              r_out_valid;
    logic [ACC_W-1:0]  r_out_value;
    logic              r_out_oor;

    // element stores
    logic [ELEM_W-1:0] mem_a [DEPTH];
    logic [ELEM_W-1:0] mem_b [DEPTH];
    logic signed [ELEM_W-1:0] r_a_rd;
    logic signed [ELEM_W-1:0] r_b_rd;

    logic [IDX_W-1:0]  w_in_row;
    logic [IDX_W-1:0]  w_in_col;
    logic [ELEM_W-1:0] w_in_elem;
    logic              w_accept;
    logic              w_in_store;
    logic [AW-1:0]     w_wr_addr;
    logic [SZW-1:0]    w_eff_rows;
    logic [SZW-1:0]    w_eff_cols;
    logic [SZW-1:0]    w_eff_inner;
    logic              w_query_oor;
    logic              w_issue;
    logic [AW-1:0]     w_addr_a;
    logic [AW-1:0]     w_addr_b;
    logic              w_mac_busy;
    logic signed [ACC_W-1:0] w_acc;
    t_mac_ctl          w_mac_ctl;

    // unpack the input word
    assign w_in_row  = s_axis_tdata[IDX_W-1:0];
    assign w_in_col  = s_axis_tdata[2*IDX_W-1:IDX_W];
    assign w_in_elem = s_axis_tdata[2*IDX_W+ELEM_W-1:2*IDX_W];

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;

    // clamp each size register to the store dimension
    assign w_eff_rows  = (SZW'(r_rows_a) > DIM_S) ? DIM_S : SZW'(r_rows_a);
    assign w_eff_cols  = (SZW'(r_cols_b) > DIM_S) ? DIM_S : SZW'(r_cols_b);
    assign w_eff_inner = (SZW'(r_inner_len) > DIM_S) ? DIM_S : SZW'(r_inner_len);

    assign w_query_oor = (SZW'(w_in_row) >= w_eff_rows) || (SZW'(w_in_col) >= w_eff_cols);

    // loads outside the physical store are dropped
    assign w_in_store = (SZW'(w_in_row) < DIM_S) && (SZW'(w_in_col) < DIM_S);
    assign w_wr_addr  = AW'(w_in_row) * DIM_A + AW'(w_in_col);

    // walk k along row of A and column of B
    assign w_issue  = (r_state == S_RUN) && (r_kcnt != r_n);
    assign w_addr_a = AW'(r_row) * DIM_A + AW'(r_kcnt);
    assign w_addr_b = AW'(r_kcnt) * DIM_A + AW'(r_col);

    // store A: one write port for loads, one read port for queries
    always_ff @(posedge i_clk) begin
        if (w_accept && (s_axis_tuser == REQ_LOAD_A) && w_in_store) begin
            mem_a[w_wr_addr] <= w_in_elem;
        end
        if (w_issue) begin
            r_a_rd <= mem_a[w_addr_a];
        end
    end

    // store B
    always_ff @(posedge i_clk) begin
        if (w_accept && (s_axis_tuser == REQ_LOAD_B) && w_in_store) begin
            mem_b[w_wr_addr] <= w_in_elem;
        end
        if (w_issue) begin
            r_b_rd <= mem_b[w_addr_b];
        end
    end

    assign w_mac_ctl.clear    = w_accept && (s_axis_tuser == REQ_QUERY);
    assign w_mac_ctl.in_valid = r_rd_v;

    mm_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_mac_ctl),
        .i_a     (r_a_rd),
        .i_b     (r_b_rd),
        .o_busy  (w_mac_busy),
        .o_acc   (w_acc)
    );

    // configuration registers; an unused index is dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_a    <= SIZE_RESET;
            r_inner_len <= SIZE_RESET;
            r_cols_b    <= SIZE_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_ROWS_A:    r_rows_a    <= i_cfg_data;
                CFG_INNER_LEN: r_inner_len <= i_cfg_data;
                CFG_COLS_B:    r_cols_b    <= i_cfg_data;
                default:       ;
            endcase
        end
    end

    // sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_kcnt      <= '0;
            r_n         <= '0;
            r_rd_v      <= 1'b0;
            r_oor       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_rd_v <= w_issue;
            // drop the result word once the sink takes it, unless a new one takes its place
            if (r_out_valid && m_axis_tready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept && (s_axis_tuser == REQ_QUERY)) begin
                        r_row  <= w_in_row;
                        r_col  <= w_in_col;
                        r_n    <= KW'(w_eff_inner);
                        r_kcnt <= '0;
                        r_oor  <= w_query_oor;
                        r_state <= w_query_oor ? S_DONE : S_RUN;
                    end
                end
                S_RUN: begin
                    if (w_issue) begin
                        r_kcnt <= r_kcnt + 1'b1;
                    end else if (!r_rd_v && !w_mac_busy) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    // hold the sum until the output register frees up
                    if (!r_out_valid || m_axis_tready) begin
                        r_out_valid <= 1'b1;
                        r_out_value <= r_oor ? '0 : w_acc;
                        r_out_oor   <= r_oor;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OUT_DATA_W-ACC_W){1'b0}}, r_out_value};
    assign m_axis_tuser  = r_out_oor;

    // an out-of-range result always carries a zero sum
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == '0))
        else $error("out-of-range result with nonzero value");

    // the k walk never passes the sum length
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN) |-> (r_kcnt <= r_n))
        else $error("k counter overran sum length");

    // the accumulator pipeline is drained outside a running query
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_RUN) |-> (!r_rd_v && !w_mac_busy))
        else $error("multiply pipeline active outside a query");

    // a result word leaves the sequencer only from the done state
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_DONE))
        else $error("result word appeared without a finished query");

endmodule

`default_nettype wire

>>> test/tb_matrix_multiply_top.sv
`timescale 1ns / 100ps

module tb_matrix_multiply_top;

    import mm_pkg::*;

    localparam int DIM         = 16;
    localparam int DRAIN_CYCLES = 24;          // drain wait, longer than the longest query
    localparam logic [1:0] REQ_SPARE  = 2'd3;  // request kind with no meaning
    localparam logic [1:0] CFG_SPARE  = 2'd3;  // register index with no register

    typedef enum logic [1:0] {
        PACE_FREE,
        PACE_SEND_GAPS,
        PACE_RECV_STALLS,
        PACE_BOTH
    } t_pace;

    typedef struct {
        logic [1:0]        kind;
        logic [IDX_W-1:0]  row;
        logic [IDX_W-1:0]  col;
        logic [ELEM_W-1:0] elem;
    } t_mm_req;

    typedef struct {
        logic [ACC_W-1:0] value;
        logic             oor;
    } t_c_elem;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [1:0]            i_cfg_index;
    logic [SIZE_W-1:0]     i_cfg_data;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic [1:0]            s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tuser;

    // shadow of the block: both element stores and the size registers
    logic [ELEM_W-1:0] mat_a [DIM*DIM];
    logic [ELEM_W-1:0] mat_b [DIM*DIM];
    logic [SIZE_W-1:0] size_rows;
    logic [SIZE_W-1:0] size_inner;
    logic [SIZE_W-1:0] size_cols;

    t_mm_req req_q[$];     // words waiting to be sent
    t_c_elem c_elem_q[$];  // C elements still owed by the block
    t_mm_req cur_req;
    logic    word_live;    // cur_req is on the bus and not yet taken
    t_pace   pace;
    int      errors;

    matrix_multiply_top #(.MAX_DIM(DIM)) uut (.*);

    always #4 i_clk = ~i_clk;

    function automatic int eff_size(input logic [SIZE_W-1:0] r);
        return (r > DIM) ? DIM : int'(r);
    endfunction

    // Update the shadow stores for a load, or queue the C element a query owes.
    function automatic void apply_request(input t_mm_req rq);
        t_c_elem e;
        longint  acc;
        int      k;
        acc = 0;
        case (rq.kind)
            REQ_LOAD_A: mat_a[rq.row*DIM + rq.col] = rq.elem;
            REQ_LOAD_B: mat_b[rq.row*DIM + rq.col] = rq.elem;
            REQ_QUERY: begin
                if (rq.row >= eff_size(size_rows) || rq.col >= eff_size(size_cols)) begin
                    e.value = '0;
                    e.oor   = 1'b1;
                end else begin
                    for (k = 0; k < eff_size(size_inner); k++)
                        acc += longint'($signed(mat_a[rq.row*DIM + k]))
                             * longint'($signed(mat_b[k*DIM + rq.col]));
                    e.value = acc[ACC_W-1:0];
                    e.oor   = 1'b0;
                end
                c_elem_q.push_back(e);
            end
            default: ;
        endcase
    endfunction

    // Driver: take accepted words at the rising edge, present the next one at the falling edge.
    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            apply_request(cur_req);
            word_live = 1'b0;
        end
    end

    always @(negedge i_clk) begin
        if (!word_live) begin
            if (i_rst_n && req_q.size() > 0 &&
                !((pace == PACE_SEND_GAPS && $urandom_range(99) < 51) ||
                  (pace == PACE_BOTH && $urandom_range(99) < 6))) begin
                cur_req = req_q.pop_front();
                word_live = 1'b1;
                s_axis_tvalid <= 1'b1;
                s_axis_tuser  <= cur_req.kind;
                s_axis_tdata  <= {cur_req.elem, cur_req.col, cur_req.row};
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Monitor: stall the result side at the falling edge, check at the rising edge.
    always @(negedge i_clk) begin
        m_axis_tready <= !((pace == PACE_RECV_STALLS && $urandom_range(99) < 51) ||
                           (pace == PACE_BOTH && $urandom_range(99) < 6));
    end

    always @(posedge i_clk) begin
        t_c_elem want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (c_elem_q.size() == 0) begin
                $display("%0t: unexpected result word value=%h oor=%b",
                         $time, m_axis_tdata, m_axis_tuser);
                errors++;
            end else begin
                want = c_elem_q.pop_front();
                if (m_axis_tdata !== {3'b000, want.value}) begin
                    $display("%0t: product mismatch expected=%h actual=%h",
                             $time, {3'b000, want.value}, m_axis_tdata);
                    errors++;
                end
                if (m_axis_tuser !== want.oor) begin
                    $display("%0t: out_of_range mismatch expected=%b actual=%b",
                             $time, want.oor, m_axis_tuser);
                    errors++;
                end
            end
        end
    end

    task automatic push_req(input logic [1:0] kind, input int row, input int col,
                            input logic [ELEM_W-1:0] elem);
        t_mm_req rq;
        rq.kind = kind;
        rq.row  = row[IDX_W-1:0];
        rq.col  = col[IDX_W-1:0];
        rq.elem = elem;
        req_q.push_back(rq);
    endtask

    // Wait until every word is sent and every result is in, then let the pipe drain.
    task automatic settle();
        while (req_q.size() > 0 || word_live || c_elem_q.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_cfg(input logic [1:0] idx, input logic [SIZE_W-1:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        forever begin
            @(posedge i_clk);
            if (o_cfg_ready) break;
        end
        case (idx)
            CFG_ROWS_A:    size_rows  = val;
            CFG_INNER_LEN: size_inner = val;
            CFG_COLS_B:    size_cols  = val;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_sizes(input logic [SIZE_W-1:0] rows, input logic [SIZE_W-1:0] inner,
                             input logic [SIZE_W-1:0] cols);
        settle();
        write_cfg(CFG_ROWS_A, rows);
        write_cfg(CFG_INNER_LEN, inner);
        write_cfg(CFG_COLS_B, cols);
    endtask

    function automatic logic [ELEM_W-1:0] pick_elem();
        case ($urandom_range(9))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'hFFFF;
            3:       return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    // Mostly land inside the configured size, sometimes anywhere in the field.
    function automatic int pick_index(input int lim);
        if (lim > 0 && $urandom_range(4) != 0)
            return $urandom_range(lim - 1);
        return $urandom_range(DIM - 1);
    endfunction

    task automatic queue_random(input int n);
        int cnt;
        int r;
        cnt = 0;
        while (cnt < n) begin
            r = $urandom_range(99);
            if (r < 35) begin
                push_req(REQ_LOAD_A, $urandom_range(15), $urandom_range(15), pick_elem());
            end else if (r < 65) begin
                push_req(REQ_LOAD_B, $urandom_range(15), $urandom_range(15), pick_elem());
            end else if (r < 95) begin
                push_req(REQ_QUERY, pick_index(eff_size(size_rows)),
                         pick_index(eff_size(size_cols)), 16'($urandom));
            end else begin
                push_req(REQ_SPARE, $urandom_range(15), $urandom_range(15), 16'($urandom));
                cnt--;  // ignored words do not count
            end
            cnt++;
        end
    endtask

    task automatic run_phase(input logic [SIZE_W-1:0] rows, input logic [SIZE_W-1:0] inner,
                             input logic [SIZE_W-1:0] cols, input t_pace p, input int n);
        set_sizes(rows, inner, cols);
        pace = p;
        queue_random(n);
    endtask

    initial begin
        #5_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        int r;
        int c;
        int i;
        i_clk         = 1'b0;
        i_rst_n       = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = CFG_ROWS_A;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = REQ_LOAD_A;
        m_axis_tready = 1'b0;
        word_live     = 1'b0;
        pace          = PACE_FREE;
        errors        = 0;
        size_rows     = SIZE_RESET;
        size_inner    = SIZE_RESET;
        size_cols     = SIZE_RESET;
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Fill both stores so no query ever reads an unwritten entry. Row 15 of A
        // and column 15 of B hold the most negative element, column 14 of B the
        // most positive, to reach the largest sums of either sign.
        for (r = 0; r < DIM; r++)
            for (c = 0; c < DIM; c++)
                push_req(REQ_LOAD_A, r, c, (r == DIM - 1) ? 16'h8000 : pick_elem());
        for (r = 0; r < DIM; r++)
            for (c = 0; c < DIM; c++)
                push_req(REQ_LOAD_B, r, c, (c == DIM - 1) ? 16'h8000 :
                                           (c == DIM - 2) ? 16'h7FFF : pick_elem());

        // Directed: extreme sums, corners, ignored kind, fresh loads read back.
        push_req(REQ_QUERY, 15, 15, 16'h0000);
        push_req(REQ_QUERY, 15, 14, 16'hFFFF);
        push_req(REQ_QUERY, 0, 0, 16'h0000);
        push_req(REQ_QUERY, 0, 15, 16'h0000);
        push_req(REQ_QUERY, 15, 0, 16'h0000);
        push_req(REQ_SPARE, 15, 15, 16'h0000);
        push_req(REQ_QUERY, 15, 15, 16'h0000);
        push_req(REQ_LOAD_A, 3, 4, 16'h7FFF);
        push_req(REQ_LOAD_B, 4, 3, 16'h7FFF);
        push_req(REQ_QUERY, 3, 3, 16'h0000);

        // Smallest sizes with an empty sum.
        set_sizes(5'd1, 5'd0, 5'd1);
        push_req(REQ_QUERY, 0, 0, 16'h0000);
        push_req(REQ_QUERY, 1, 0, 16'h0000);
        push_req(REQ_QUERY, 0, 1, 16'h0000);
        push_req(REQ_QUERY, 15, 15, 16'h0000);

        // Zero rows, then zero columns: everything is out of range.
        set_sizes(5'd0, 5'd31, 5'd31);
        push_req(REQ_QUERY, 0, 0, 16'h0000);
        set_sizes(5'd31, 5'd31, 5'd0);
        push_req(REQ_QUERY, 0, 0, 16'h0000);

        // Sizes above the store clamp to it; the spare index changes nothing.
        set_sizes(5'd31, 5'd31, 5'd31);
        write_cfg(CFG_SPARE, 5'd1);
        push_req(REQ_QUERY, 15, 15, 16'h0000);
        push_req(REQ_QUERY, 15, 14, 16'h0000);

        run_phase(5'd16, 5'd16, 5'd16, PACE_FREE,        200);
        run_phase(5'd5,  5'd7,  5'd9,  PACE_SEND_GAPS,   150);
        run_phase(5'd31, 5'd31, 5'd31, PACE_RECV_STALLS, 150);
        run_phase(5'd1,  5'd1,  5'd1,  PACE_BOTH,        100);
        run_phase(5'd0,  5'd16, 5'd16, PACE_SEND_GAPS,    40);
        run_phase(5'd16, 5'd0,  5'd16, PACE_RECV_STALLS,  40);
        for (i = 0; i < 4; i++)
            run_phase(5'($urandom_range(31)), 5'($urandom_range(31)),
                      5'($urandom_range(31)), t_pace'(i), 30);
        settle();

        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
